// ===== hdl/sobel_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sobel_pkg;

  // Geometry limits and field widths
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int SAMPLE_W       = 8;
  localparam int GEOM_W         = 11;
  localparam int THR_W          = 8;
  localparam int VOTE_W         = 2;
  localparam int ADDR_W         = 5;
  localparam int DATA_W         = 32;
  localparam int SUM_W          = 10;
  localparam int MAG_W          = 17;
  localparam int PROD_W         = 22;

  // Register reset values
  localparam logic              COLOR_MODE_RST = 1'b0;
  localparam logic [GEOM_W-1:0] IMG_W_RST      = 11'd1024;
  localparam logic [GEOM_W-1:0] IMG_H_RST      = 11'd1024;
  localparam logic [THR_W-1:0]  MAG_THR_RST    = 8'd5;
  localparam logic [VOTE_W-1:0] VOTE_THR_RST   = 2'd2;
  localparam logic [MAG_W-1:0]  THR_SQ_RST     =
    MAG_W'((int'(MAG_THR_RST) + 1) * (int'(MAG_THR_RST) + 1));

  // Reciprocals for the neighbour-count division, exact for sums up to 1020
  localparam int RECIP6 = 683;
  localparam int SHIFT6 = 12;
  localparam int RECIP9 = 3641;
  localparam int SHIFT9 = 15;

  typedef struct packed {
    logic [SAMPLE_W-1:0] blue;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] red;
  } pix_t;

  typedef struct packed {
    pix_t older;
    pix_t newer;
  } line_pair_t;

  typedef enum logic [2:0] {
    REG_COLOR_MODE,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_MAG_THR,
    REG_VOTE_THR
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIV_4,
    DIV_6,
    DIV_9
  } div_t;

  // Weighted 1-2-1 sum of three samples
  function automatic logic [SUM_W-1:0] tap_sum(input logic [SAMPLE_W-1:0] a,
                                               input logic [SAMPLE_W-1:0] m,
                                               input logic [SAMPLE_W-1:0] c);
    return {2'b00, a} + {1'b0, m, 1'b0} + {2'b00, c};
  endfunction

  function automatic logic [SUM_W-1:0] abs_diff(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sobel_edge_threshold_core.sv =====
// Sobel edge detector with magnitude threshold and RGB channel vote.
// Input channel (in_valid/in_stall): one pixel per beat in raster order,
// then image_width+1 beats with in_flush high to drain the last results.
// A flush beat before the frame is complete is taken and dropped.
// Result channel (out_valid/out_stall): one beat per pixel, edge flag and
// a last_in_frame marker on the final pixel of the frame.
// Throughput: one input beat per clock while in_stall is low. The line
// memory is read ahead at the next column, so it never limits the rate.
// The result for pixel k is produced from the beat that brings pixel
// k+image_width+1 and passes the window, sums, divide, square and vote stages.
// When the receiver stalls, the five pipeline stages fill and hold, and
// in_stall rises only once every stage is occupied.
// Reset clears counters, pipeline valids and the registers to their
// defaults; the line memory is not cleared, as it is only read where the
// current frame has written it. Geometry writes restart the frame.
// Registers via APB (pready always high) at byte address 4*index:
// color_mode, image_width, image_height, mag_threshold, vote_threshold.
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_threshold_core #(
  parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // pixel input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sobel_pkg::SAMPLE_W-1:0]  in_red,
  input  logic [sobel_pkg::SAMPLE_W-1:0]  in_green,
  input  logic [sobel_pkg::SAMPLE_W-1:0]  in_blue,
  input  logic                            in_flush,
  // result output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_edge_res,
  output logic                            out_last_in_frame,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sobel_pkg::ADDR_W-1:0]    paddr,
  input  logic [sobel_pkg::DATA_W-1:0]    pwdata,
  output logic [sobel_pkg::DATA_W-1:0]    prdata,
  output logic                            pready
);
  import sobel_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int HCW = $clog2(MAX_HEIGHT);

  function automatic logic [CW-1:0] width_m1(input logic [GEOM_W-1:0] v);
    int e;
    e = int'(v);
    if (e < 3) e = 3;
    if (e > MAX_WIDTH) e = MAX_WIDTH;
    return CW'(e - 1);
  endfunction

  function automatic logic [HCW-1:0] height_m1(input logic [GEOM_W-1:0] v);
    int e;
    e = int'(v);
    if (e < 3) e = 3;
    if (e > MAX_HEIGHT) e = MAX_HEIGHT;
    return HCW'(e - 1);
  endfunction

  // Configuration registers
  logic              color_mode_r;
  logic [GEOM_W-1:0] image_width_r;
  logic [GEOM_W-1:0] image_height_r;
  logic [THR_W-1:0]  mag_thr_r;
  logic [VOTE_W-1:0] vote_thr_r;
  logic [MAG_W-1:0]  thr_sq_r;
  logic [CW-1:0]     wm1_r;
  logic [HCW-1:0]    hm1_r;

  reg_idx_t cfg_idx;
  logic     cfg_wr;
  logic     geom_wr;

  // Frame position
  logic [CW-1:0]  col_r, col_nxt;
  logic [HCW-1:0] row_r, row_nxt;
  logic           all_in_r, all_in_nxt;
  logic [CW-1:0]  ccol_r, ccol_nxt;
  logic [HCW-1:0] crow_r, crow_nxt;

  logic in_acc, step, px_wr, emit;
  logic col_last, row_last, cen_last;

  // Line memory and window
  line_pair_t line_mem [MAX_WIDTH];
  line_pair_t rd_r;
  pix_t       in_pix;
  pix_t       win_r   [3][3];
  pix_t       win_nxt [3][3];
  logic       row_ok  [3];
  logic       col_ok  [3];

  // Pipeline stages
  logic             s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;
  logic             s1_rdy, s2_rdy, s3_rdy, s4_rdy, out_rdy;
  pix_t             s1_pix_r [3][3];
  div_t             s1_div_r, s2_div_r;
  logic             s1_last_r, s2_last_r, s3_last_r, s4_last_r;
  logic [SUM_W-1:0] mv_nxt [3];
  logic [SUM_W-1:0] mh_nxt [3];
  logic [SUM_W-1:0] s2_mv_r [3];
  logic [SUM_W-1:0] s2_mh_r [3];
  logic [7:0]       qv_nxt [3];
  logic [7:0]       qh_nxt [3];
  logic [7:0]       s3_qv_r [3];
  logic [7:0]       s3_qh_r [3];
  logic [PROD_W-1:0] pv6, ph6, pv9, ph9;
  logic [2:0]       edge_nxt;
  logic [2:0]       s4_edge_r;
  logic [MAG_W-1:0] mag;
  logic [1:0]       n_edge;
  logic             vote_edge;
  logic             out_edge_r, out_last_r;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    geom_wr = cfg_wr && (cfg_idx inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT});
  end

  // Update the registers on the access beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r   <= COLOR_MODE_RST;
      image_width_r  <= IMG_W_RST;
      image_height_r <= IMG_H_RST;
      mag_thr_r      <= MAG_THR_RST;
      vote_thr_r     <= VOTE_THR_RST;
      thr_sq_r       <= THR_SQ_RST;
      wm1_r          <= width_m1(IMG_W_RST);
      hm1_r          <= height_m1(IMG_H_RST);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_COLOR_MODE: begin
          color_mode_r <= pwdata[0];
        end
        REG_IMAGE_WIDTH: begin
          image_width_r <= pwdata[GEOM_W-1:0];
          wm1_r         <= width_m1(pwdata[GEOM_W-1:0]);
        end
        REG_IMAGE_HEIGHT: begin
          image_height_r <= pwdata[GEOM_W-1:0];
          hm1_r          <= height_m1(pwdata[GEOM_W-1:0]);
        end
        REG_MAG_THR: begin
          mag_thr_r <= pwdata[THR_W-1:0];
          // edge when floor sqrt(mag) > t, i.e. mag >= (t+1)^2
          thr_sq_r  <= MAG_W'(({1'b0, pwdata[THR_W-1:0]} + 9'd1) *
                              ({1'b0, pwdata[THR_W-1:0]} + 9'd1));
        end
        REG_VOTE_THR: begin
          vote_thr_r <= pwdata[VOTE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      REG_COLOR_MODE:   prdata = DATA_W'(color_mode_r);
      REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width_r);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height_r);
      REG_MAG_THR:      prdata = DATA_W'(mag_thr_r);
      REG_VOTE_THR:     prdata = DATA_W'(vote_thr_r);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Frame counters
  // ---------------------------------------------------------------------
  assign in_stall = !s1_rdy;
  assign in_pix   = '{blue: in_blue, green: in_green, red: in_red};

  always_comb begin
    in_acc   = in_valid && !in_stall;
    step     = in_acc && (all_in_r || !in_flush);
    px_wr    = in_acc && !all_in_r && !in_flush;
    col_last = (col_r == wm1_r);
    row_last = (row_r == hm1_r);
    cen_last = (crow_r == hm1_r) && (ccol_r == wm1_r);
    // a centre is complete once pixel index width+1 has arrived
    emit     = step && (all_in_r || (row_r > HCW'(1)) ||
                        ((row_r == HCW'(1)) && (col_r != '0)));

    col_nxt    = col_r;
    row_nxt    = row_r;
    all_in_nxt = all_in_r;
    ccol_nxt   = ccol_r;
    crow_nxt   = crow_r;

    // advance the incoming position
    if (step) begin
      col_nxt = col_last ? '0 : col_r + 1'b1;
      if (px_wr && col_last) begin
        if (row_last) begin
          all_in_nxt = 1'b1;
          row_nxt    = '0;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end
    end

    // advance the centre; the final one restarts the frame
    if (emit) begin
      if (cen_last) begin
        col_nxt    = '0;
        row_nxt    = '0;
        all_in_nxt = 1'b0;
        ccol_nxt   = '0;
        crow_nxt   = '0;
      end else if (ccol_r == wm1_r) begin
        ccol_nxt = '0;
        crow_nxt = crow_r + 1'b1;
      end else begin
        ccol_nxt = ccol_r + 1'b1;
      end
    end

    // geometry change drops the frame
    if (geom_wr) begin
      col_nxt    = '0;
      row_nxt    = '0;
      all_in_nxt = 1'b0;
      ccol_nxt   = '0;
      crow_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      all_in_r <= 1'b0;
      ccol_r   <= '0;
      crow_r   <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      all_in_r <= all_in_nxt;
      ccol_r   <= ccol_nxt;
      crow_r   <= crow_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Line memory: two rows per column, read one beat ahead
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (px_wr) begin
      line_mem[col_r] <= '{older: rd_r.newer, newer: in_pix};
    end
    rd_r <= line_mem[col_nxt];
  end

  // ---------------------------------------------------------------------
  // 3x3 window: shift left, new column enters on the right
  // ---------------------------------------------------------------------
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = rd_r.older;
    win_nxt[1][2] = rd_r.newer;
    win_nxt[2][2] = in_pix;

    row_ok[0] = (crow_r != '0);
    row_ok[1] = 1'b1;
    row_ok[2] = (crow_r != hm1_r);
    col_ok[0] = (ccol_r != '0);
    col_ok[1] = 1'b1;
    col_ok[2] = (ccol_r != wm1_r);
  end

  always_ff @(posedge clk) begin
    if (step) begin
      win_r <= win_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: masked window snapshot
  // ---------------------------------------------------------------------
  assign out_rdy = !out_valid_r || !out_stall;
  assign s4_rdy  = !s4_v_r || out_rdy;
  assign s3_rdy  = !s3_v_r || s4_rdy;
  assign s2_rdy  = !s2_v_r || s3_rdy;
  assign s1_rdy  = !s1_v_r || s2_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && emit) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          s1_pix_r[r][c] <= (row_ok[r] && col_ok[c]) ? win_nxt[r][c] : '0;
        end
      end
      if (row_ok[0] && row_ok[2] && col_ok[0] && col_ok[2]) begin
        s1_div_r <= DIV_9;
      end else if ((row_ok[0] != row_ok[2]) && (col_ok[0] != col_ok[2])) begin
        s1_div_r <= DIV_4;
      end else begin
        s1_div_r <= DIV_6;
      end
      s1_last_r <= !row_ok[2] && !col_ok[2];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: gradient magnitudes per channel
  // ---------------------------------------------------------------------
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mv_nxt[ch] = abs_diff(
        tap_sum(s1_pix_r[2][0][8*ch +: 8], s1_pix_r[2][1][8*ch +: 8],
                s1_pix_r[2][2][8*ch +: 8]),
        tap_sum(s1_pix_r[0][0][8*ch +: 8], s1_pix_r[0][1][8*ch +: 8],
                s1_pix_r[0][2][8*ch +: 8]));
      mh_nxt[ch] = abs_diff(
        tap_sum(s1_pix_r[0][2][8*ch +: 8], s1_pix_r[1][2][8*ch +: 8],
                s1_pix_r[2][2][8*ch +: 8]),
        tap_sum(s1_pix_r[0][0][8*ch +: 8], s1_pix_r[1][0][8*ch +: 8],
                s1_pix_r[2][0][8*ch +: 8]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_mv_r   <= mv_nxt;
      s2_mh_r   <= mh_nxt;
      s2_div_r  <= s1_div_r;
      s2_last_r <= s1_last_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: divide by neighbour count, truncating (sign is squared away)
  // ---------------------------------------------------------------------
  always_comb begin
    pv6 = '0;
    ph6 = '0;
    pv9 = '0;
    ph9 = '0;
    for (int ch = 0; ch < 3; ch++) begin
      pv6 = PROD_W'(s2_mv_r[ch]) * PROD_W'(RECIP6);
      ph6 = PROD_W'(s2_mh_r[ch]) * PROD_W'(RECIP6);
      pv9 = PROD_W'(s2_mv_r[ch]) * PROD_W'(RECIP9);
      ph9 = PROD_W'(s2_mh_r[ch]) * PROD_W'(RECIP9);
      case (s2_div_r)
        DIV_4: begin
          qv_nxt[ch] = s2_mv_r[ch][SUM_W-1:2];
          qh_nxt[ch] = s2_mh_r[ch][SUM_W-1:2];
        end
        DIV_6: begin
          qv_nxt[ch] = 8'(pv6 >> SHIFT6);
          qh_nxt[ch] = 8'(ph6 >> SHIFT6);
        end
        default: begin
          qv_nxt[ch] = 8'(pv9 >> SHIFT9);
          qh_nxt[ch] = 8'(ph9 >> SHIFT9);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_v_r) begin
      s3_qv_r   <= qv_nxt;
      s3_qh_r   <= qh_nxt;
      s3_last_r <= s2_last_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: squared magnitude against threshold
  // ---------------------------------------------------------------------
  always_comb begin
    mag = '0;
    for (int ch = 0; ch < 3; ch++) begin
      mag = MAG_W'(16'(s3_qv_r[ch] * s3_qv_r[ch])) +
            MAG_W'(16'(s3_qh_r[ch] * s3_qh_r[ch]));
      edge_nxt[ch] = (mag >= thr_sq_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_rdy) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_rdy && s3_v_r) begin
      s4_edge_r <= edge_nxt;
      s4_last_r <= s3_last_r;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: gray decision or channel vote
  // ---------------------------------------------------------------------
  always_comb begin
    n_edge    = 2'(s4_edge_r[0]) + 2'(s4_edge_r[1]) + 2'(s4_edge_r[2]);
    vote_edge = color_mode_r ? (n_edge > vote_thr_r) : s4_edge_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && s4_v_r) begin
      out_edge_r <= vote_edge;
      out_last_r <= s4_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_edge_res      = out_edge_r;
  assign out_last_in_frame = out_last_r;

`ifndef NO_ASSERTIONS
  // Input only backs up once the whole pipeline is full behind a stall
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && s3_v_r && s4_v_r && out_valid_r && out_stall))
    else $error("input stalled with a free pipeline stage");

  // A blocked stage keeps its token
  a_s4_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && !out_rdy) |=> (s4_v_r && $stable(s4_edge_r) && $stable(s4_last_r)))
    else $error("stage 4 changed while blocked");

  // Final centre of the frame restarts all counters
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && cen_last) |=> (col_r == '0 && crow_r == '0 && ccol_r == '0 && !all_in_r))
    else $error("counters not cleared after final pixel");

  // While draining, the centre column trails the read column by one
  a_drain_align: assert property (@(posedge clk) disable iff (!rst_n)
    all_in_r |-> ((col_r == '0) ? (ccol_r == wm1_r) : (ccol_r == col_r - 1'b1)))
    else $error("centre and window columns out of step");
`endif

endmodule

`default_nettype wire
